@@ src/grid_lipschitz_slope_max_assert.svh @@
// Assertion macros for the grid Lipschitz slope estimator.
// Needs signals named clock and reset in the including module.
`ifndef GRID_LIPSCHITZ_SLOPE_MAX_ASSERT_SVH
`define GRID_LIPSCHITZ_SLOPE_MAX_ASSERT_SVH

// expression must hold on every clock edge outside reset
`define GLSM_ASSERT_HOLD(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// antecedent on one edge implies consequent on the next
`define GLSM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/glsm_pkg.sv @@
// Shared constants and types for the grid Lipschitz slope estimator.
// No dependencies.
package glsm_pkg;

   localparam int GRID_MAX    = 1024;
   localparam int COL_W       = $clog2(GRID_MAX);
   localparam int GRID_SIZE_W = 11;
   // wide enough for the size register and for GRID_MAX itself
   localparam int CMP_W       = (GRID_SIZE_W > COL_W + 1) ? GRID_SIZE_W : COL_W + 1;

   localparam int SAMPLE_W = 32;
   localparam int STEP_W   = 32;
   localparam int FRAC_W   = 16;
   localparam int SLOPE_W  = 48;
   localparam int EST_W    = 48;
   localparam int PROD_W   = SAMPLE_W + STEP_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_SIZE = 2'd0,
      CSR_INV_ROW   = 2'd1,
      CSR_INV_COL   = 2'd2,
      CSR_INV_DIAG  = 2'd3
   } csr_index_type;

   localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RST = 11'd16;
   localparam logic [STEP_W-1:0]      INV_ROW_RST   = 32'd65536;
   localparam logic [STEP_W-1:0]      INV_COL_RST   = 32'd65536;
   localparam logic [STEP_W-1:0]      INV_DIAG_RST  = 32'd46341;

   // x * 1.2 = x + x / 5, with x / 5 done on two 24-bit halves
   localparam int HALF_W     = EST_W / 2;
   localparam int DIV_IN_W   = HALF_W + 3;
   localparam int DIV5_SHIFT = 29;
   localparam logic [DIV_IN_W-1:0] DIV5_MUL = 27'd107374183; // ceil(2^29 / 5)

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   // which neighbour pairs take part, plus end-of-grid mark
   typedef struct packed {
      logic use_left;
      logic use_up;
      logic use_ul;
      logic use_ur;
      logic last;
   } pair_sel_type;

endpackage

@@ src/glsm_ram.sv @@
// Generic RAM: one write port, two registered read ports, read-old on collision.
// No dependencies.
module glsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

@@ src/grid_lipschitz_slope_max.sv @@
// Grid Lipschitz slope estimator, top level.
// Depends on glsm_pkg, glsm_ram and grid_lipschitz_slope_max_assert.svh.

// Samples of a square grid arrive in raster order, one per clock while req_stall is low.
// Each sample is compared against its left, upper, upper-left and upper-right
// neighbours; the slopes |diff| * inv_step are folded into a running maximum,
// and on the last sample of the grid 1.2 times that maximum (saturating at
// 2^48-1) is returned. The previous row lives in one RAM with a write port and
// two read ports. The result of a grid passes the difference, slope, maximum
// and scaling registers into a result queue, whose non-empty state is rsp_valid.
// Up to 8 results can wait for the consumer; req_stall rises only when 8 are
// outstanding. The row store has no clearing pass and is usable straight out
// of reset. Registers may be written only while no transaction is in flight.
`include "grid_lipschitz_slope_max_assert.svh"

module grid_lipschitz_slope_max
   import glsm_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [SAMPLE_W-1:0]   req_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [EST_W-1:0]             rsp_estimate,
   output logic                         rsp_saturated,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   function automatic logic [SAMPLE_W-1:0] abs_diff(logic [SAMPLE_W-1:0] a,
                                                    logic [SAMPLE_W-1:0] b);
      logic [SAMPLE_W:0] d;
      logic [SAMPLE_W:0] mag;
      d   = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
      mag = d[SAMPLE_W] ? (~d + 1'b1) : d;
      return mag[SAMPLE_W-1:0];
   endfunction

   function automatic logic [SLOPE_W-1:0] max48(logic [SLOPE_W-1:0] a,
                                                logic [SLOPE_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   // configuration
   logic [GRID_SIZE_W-1:0] grid_size_ff;
   logic [STEP_W-1:0]      inv_row_ff;
   logic [STEP_W-1:0]      inv_col_ff;
   logic [STEP_W-1:0]      inv_diag_ff;

   // raster position
   logic [COL_W-1:0] col_count_ff, col_count_in;
   logic [COL_W-1:0] row_count_ff, row_count_in;
   logic [CMP_W-1:0] size_eff;
   logic [CMP_W-1:0] size_ext;
   logic             last_col, last_row, is_last, req_acc;
   pair_sel_type     sel0;

   // stage 1: sample, left neighbour, row store read data
   logic [SAMPLE_W-1:0] left_ff;
   logic [SAMPLE_W-1:0] s1_ff, left1_ff, ul_ff;
   logic [SAMPLE_W-1:0] ram_rd_a, ram_rd_b;
   pair_sel_type        sel1_ff;
   logic                v1_ff;

   // stage 2: differences
   logic [SAMPLE_W-1:0] d_left_ff, d_up_ff, d_ul_ff, d_ur_ff;
   logic                v2_ff, last2_ff;

   // stage 3: slopes
   logic [PROD_W-1:0]   p_left, p_up, p_ul, p_ur;
   logic [SLOPE_W-1:0]  sl_left_ff, sl_up_ff, sl_ul_ff, sl_ur_ff;
   logic                v3_ff, last3_ff;

   // stage 4: running maximum
   logic [SLOPE_W-1:0]  slope_max_ff, max_all;
   logic [SLOPE_W-1:0]  fin_ff;
   logic                vf_ff;

   // scaling by 1.2
   logic [2*DIV_IN_W-1:0] qh_prod, ql_prod;
   logic [DIV_IN_W-1:0]   rem_wide;
   logic [EST_W-1:0]      e1_x_ff, e2_x_ff, e3_x_ff;
   logic [HALF_W-1:0]     e1_qh_ff, e2_qh_ff, e3_qh_ff, e3_ql_ff;
   logic [DIV_IN_W-1:0]   e2_y_ff;
   logic                  e1_v_ff, e2_v_ff, e3_v_ff;
   logic [EST_W:0]        scaled;

   // result queue
   logic [EST_W-1:0]      fifo_est_ff [FIFO_DEPTH];
   logic                  fifo_sat_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] fifo_cnt_ff, pending_ff;
   logic                  rsp_acc;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= GRID_SIZE_RST;
         inv_row_ff   <= INV_ROW_RST;
         inv_col_ff   <= INV_COL_RST;
         inv_diag_ff  <= INV_DIAG_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_GRID_SIZE: grid_size_ff <= csr_wdata[GRID_SIZE_W-1:0];
            CSR_INV_ROW:   inv_row_ff   <= csr_wdata[STEP_W-1:0];
            CSR_INV_COL:   inv_col_ff   <= csr_wdata[STEP_W-1:0];
            CSR_INV_DIAG:  inv_diag_ff  <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------------- stage 0
   assign req_stall = (pending_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign req_acc   = req_valid && !req_stall;

   assign size_ext = CMP_W'(grid_size_ff);

   always_comb begin
      if (size_ext == '0) begin
         size_eff = CMP_W'(1);
      end else if (size_ext > CMP_W'(GRID_MAX)) begin
         size_eff = CMP_W'(GRID_MAX);
      end else begin
         size_eff = size_ext;
      end
   end

   assign last_col = (CMP_W'(col_count_ff) + CMP_W'(1)) >= size_eff;
   assign last_row = (CMP_W'(row_count_ff) + CMP_W'(1)) >= size_eff;
   assign is_last  = last_col && last_row;

   always_comb begin
      sel0.use_left = (col_count_ff != '0);
      sel0.use_up   = (row_count_ff != '0);
      sel0.use_ul   = (row_count_ff != '0) && (col_count_ff != '0);
      sel0.use_ur   = (row_count_ff != '0) && !last_col
                      && (col_count_ff != COL_W'(GRID_MAX - 1));
      sel0.last     = is_last;
   end

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (req_acc) begin
         if (is_last) begin
            col_count_in = '0;
            row_count_in = '0;
         end else if (last_col) begin
            col_count_in = '0;
            row_count_in = row_count_ff + 1'b1;
         end else begin
            col_count_in = col_count_ff + 1'b1;
         end
      end
   end

   // upper neighbour at this column, upper-right at the next; read-old keeps
   // the previous row visible while this sample overwrites it
   glsm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (GRID_MAX)
   ) u_line_store (
      .clock     (clock),
      .wr_en     (req_acc),
      .wr_addr   (col_count_ff),
      .wr_data   (req_sample),
      .rd_a_addr (col_count_ff),
      .rd_a_data (ram_rd_a),
      .rd_b_addr (col_count_ff + 1'b1),
      .rd_b_data (ram_rd_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         v1_ff        <= 1'b0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         v1_ff        <= req_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         left_ff  <= req_sample;
         s1_ff    <= req_sample;
         left1_ff <= left_ff;
         sel1_ff  <= sel0;
      end
      // upper value of one transaction is the upper-left of the next
      if (v1_ff) begin
         ul_ff <= ram_rd_a;
      end
   end

   // --------------------------------------------------------------- stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_left_ff <= sel1_ff.use_left ? abs_diff(s1_ff, left1_ff) : '0;
      d_up_ff   <= sel1_ff.use_up   ? abs_diff(s1_ff, ram_rd_a) : '0;
      d_ul_ff   <= sel1_ff.use_ul   ? abs_diff(s1_ff, ul_ff)    : '0;
      d_ur_ff   <= sel1_ff.use_ur   ? abs_diff(s1_ff, ram_rd_b) : '0;
      last2_ff  <= v1_ff && sel1_ff.last;
   end

   // --------------------------------------------------------------- stage 2
   assign p_left = PROD_W'(d_left_ff) * PROD_W'(inv_col_ff);
   assign p_up   = PROD_W'(d_up_ff)   * PROD_W'(inv_row_ff);
   assign p_ul   = PROD_W'(d_ul_ff)   * PROD_W'(inv_diag_ff);
   assign p_ur   = PROD_W'(d_ur_ff)   * PROD_W'(inv_diag_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      sl_left_ff <= p_left[FRAC_W +: SLOPE_W];
      sl_up_ff   <= p_up[FRAC_W +: SLOPE_W];
      sl_ul_ff   <= p_ul[FRAC_W +: SLOPE_W];
      sl_ur_ff   <= p_ur[FRAC_W +: SLOPE_W];
      last3_ff   <= v2_ff && last2_ff;
   end

   // --------------------------------------------------------------- stage 3
   assign max_all = max48(max48(sl_left_ff, sl_up_ff),
                          max48(sl_ul_ff, max48(sl_ur_ff, slope_max_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_max_ff <= '0;
         vf_ff        <= 1'b0;
      end else begin
         vf_ff <= v3_ff && last3_ff;
         if (v3_ff) begin
            slope_max_ff <= last3_ff ? '0 : max_all;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (v3_ff && last3_ff) begin
         fin_ff <= max_all;
      end
   end

   // ------------------------------------------------------- scaling by 1.2
   assign qh_prod  = (2*DIV_IN_W)'(fin_ff[EST_W-1 -: HALF_W]) * (2*DIV_IN_W)'(DIV5_MUL);
   assign rem_wide = DIV_IN_W'(e1_x_ff[EST_W-1 -: HALF_W])
                     - ((DIV_IN_W'(e1_qh_ff) << 2) + DIV_IN_W'(e1_qh_ff));
   assign ql_prod  = (2*DIV_IN_W)'(e2_y_ff) * (2*DIV_IN_W)'(DIV5_MUL);
   assign scaled   = (EST_W+1)'(e3_x_ff) + {1'b0, e3_qh_ff, {HALF_W{1'b0}}}
                     + (EST_W+1)'(e3_ql_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_v_ff <= 1'b0;
         e2_v_ff <= 1'b0;
         e3_v_ff <= 1'b0;
      end else begin
         e1_v_ff <= vf_ff;
         e2_v_ff <= e1_v_ff;
         e3_v_ff <= e2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      e1_x_ff  <= fin_ff;
      e1_qh_ff <= qh_prod[DIV5_SHIFT +: HALF_W];
      e2_x_ff  <= e1_x_ff;
      e2_qh_ff <= e1_qh_ff;
      // remainder of the upper half is below 5, so it fits three bits
      e2_y_ff  <= {rem_wide[2:0], e1_x_ff[HALF_W-1:0]};
      e3_x_ff  <= e2_x_ff;
      e3_qh_ff <= e2_qh_ff;
      e3_ql_ff <= ql_prod[DIV5_SHIFT +: HALF_W];
   end

   // ---------------------------------------------------------- result queue
   assign rsp_valid     = (fifo_cnt_ff != '0);
   assign rsp_acc       = rsp_valid && !rsp_stall;
   assign rsp_estimate  = fifo_est_ff[rd_ptr_ff];
   assign rsp_saturated = fifo_sat_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (e3_v_ff) begin
         fifo_est_ff[wr_ptr_ff] <= scaled[EST_W] ? {EST_W{1'b1}} : scaled[EST_W-1:0];
         fifo_sat_ff[wr_ptr_ff] <= scaled[EST_W];
      end
   end

   // pending counts grids taken but not yet delivered: bounds the queue
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         pending_ff  <= '0;
      end else begin
         if (e3_v_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rsp_acc) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         fifo_cnt_ff <= fifo_cnt_ff + FIFO_CNT_W'(e3_v_ff) - FIFO_CNT_W'(rsp_acc);
         pending_ff  <= pending_ff + FIFO_CNT_W'(req_acc && is_last)
                        - FIFO_CNT_W'(rsp_acc);
      end
   end

   // ------------------------------------------------------------ assertions
   `GLSM_ASSERT_HOLD(a_queue_within_pending, fifo_cnt_ff <= pending_ff, "queue exceeds outstanding grids")
   `GLSM_ASSERT_NEXT(a_grid_restart, req_acc && is_last, col_count_ff == '0 && row_count_ff == '0, "raster position not cleared after last sample")
   `GLSM_ASSERT_NEXT(a_push_shows, e3_v_ff, rsp_valid, "queued result not presented")

endmodule
